// ===== src/crc32e_pkg.sv =====
// Shared types, constants and the CRC table function for the CRC-32 engine.
`timescale 1ns / 1ps
`default_nettype none
package crc32e_pkg;

   localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
   localparam logic [7:0]  LOWER_A   = 8'h61;
   localparam logic [7:0]  LOWER_Z   = 8'h7A;
   localparam logic [7:0]  CASE_BIT  = 8'h20;
   localparam logic [7:0]  EXT_ONES  = 8'hFF;
   localparam logic [7:0]  EXT_ZEROS = 8'h00;

   // One classified word as it waits between front and back.
   typedef struct packed {
      logic [7:0]  data_byte;   // already upper-cased in string mode
      logic        init;        // load init_value before folding
      logic [31:0] init_value;
      logic        string_mode; // mode in force for this word
      logic        last_byte;
   } item_type;

   // One table step, MSB first: table entry for top byte xor b, shifted in.
   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] t;
      t = {crc[31:24] ^ b, 24'h0};
      for (int k = 0; k < 8; k++) begin
         if (t[31]) begin
            t = {t[30:0], 1'b0} ^ CRC_POLY;
         end else begin
            t = {t[30:0], 1'b0};
         end
      end
      return {crc[23:0], 8'h0} ^ t;
   endfunction

endpackage
`default_nettype wire

// ===== src/crc32e_front.sv =====
// Front end: takes request words, tracks the message mode and classifies each byte.
`timescale 1ns / 1ps
`default_nettype none
module crc32e_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  first_byte,
   input  wire logic                  last_byte,
   input  wire logic                  string_mode,
   input  wire logic [31:0]           seed,
   output      crc32e_pkg::item_type  item
);
   import crc32e_pkg::*;

   logic mode_ff;
   logic mode_in;
   logic is_lower;

   // mode is sampled on the first byte of a message and held after
   assign mode_in  = first_byte ? string_mode : mode_ff;
   assign is_lower = (data_byte >= LOWER_A) && (data_byte <= LOWER_Z);

   always_comb begin
      item.data_byte   = (mode_in && is_lower) ? (data_byte - CASE_BIT) : data_byte;
      item.init        = first_byte;
      item.init_value  = string_mode ? CRC_ONES : ~seed;
      item.string_mode = mode_in;
      item.last_byte   = last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/crc32e_queue.sv =====
// Two-entry queue between the classifying front and the CRC back end.
`timescale 1ns / 1ps
`default_nettype none
module crc32e_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire crc32e_pkg::item_type  push_item,
   output      logic                  full,
   input  wire logic                  pop,
   output      logic                  head_valid,
   output      crc32e_pkg::item_type  head_item
);
   import crc32e_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== src/crc32e_back.sv =====
// Back end: folds queued bytes into the CRC register and holds the response word.
`timescale 1ns / 1ps
`default_nettype none
module crc32e_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire crc32e_pkg::item_type  head_item,
   output      logic                  pop,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [31:0]           rsp_crc_value,
   output      logic                  rsp_is_final
);
   import crc32e_pkg::*;

   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] crc_value_ff;
   logic        is_final_ff;
   logic [31:0] start;
   logic [31:0] fold_one;
   logic [31:0] fold_two;
   logic [7:0]  ext_byte;

   // output slot is free or drains this cycle
   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      start    = head_item.init ? head_item.init_value : crc_ff;
      fold_one = crc_fold(start, head_item.data_byte);
      // string mode folds the sign extension of the byte as a second step
      ext_byte = head_item.data_byte[7] ? EXT_ONES : EXT_ZEROS;
      fold_two = crc_fold(fold_one, ext_byte);
      crc_in   = head_item.string_mode ? fold_two : fold_one;
      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            crc_ff <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         crc_value_ff <= ~crc_in;
         is_final_ff  <= head_item.last_byte;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = crc_value_ff;
   assign rsp_is_final  = is_final_ff;

endmodule
`default_nettype wire

// ===== src/crc32_msb_first_engine.sv =====
// Path: an accepted word is first written into a queue entry, then its folded CRC
// is registered in the response register.
// Throughput: one byte per cycle while rsp_stall is low; both table steps of string mode run in the back end's cycle.
// req_stall rises only when the two-entry queue is full.
// Reset: CRC register to all ones, mode to data, queue and response emptied.
`timescale 1ns / 1ps
`default_nettype none
module crc32_msb_first_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_byte,
   input  wire logic        req_last_byte,
   input  wire logic        req_string_mode,
   input  wire logic [31:0] req_seed,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_crc_value,
   output      logic        rsp_is_final
);
   import crc32e_pkg::*;

   item_type front_item;
   item_type head_item;
   logic     accept;
   logic     full;
   logic     head_valid;
   logic     pop;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   crc32e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .first_byte  (req_first_byte),
      .last_byte   (req_last_byte),
      .string_mode (req_string_mode),
      .seed        (req_seed),
      .item        (front_item)
   );

   crc32e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_item  (front_item),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   crc32e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_crc_value (rsp_crc_value),
      .rsp_is_final  (rsp_is_final)
   );

endmodule
`default_nettype wire
